### rtl/tbh_pkg.sv
`timescale 1ns / 1ps

package tbh_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int POS_X_W = 9;
    localparam int HIST_N  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0]  RST_FIRST_HEADER  = 8'h2C;
    localparam logic [BYTE_W-1:0]  RST_SECOND_HEADER = 8'h12;
    localparam logic [BYTE_W-1:0]  RST_END_MARKER    = 8'h5B;
    localparam logic [COUNT_W-1:0] RST_MAX_FRAME_LEN = 4'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_HEADER  = 2'd0,
        CFG_SECOND_HEADER = 2'd1,
        CFG_END_MARKER    = 2'd2,
        CFG_MAX_FRAME_LEN = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HEAD1 = 2'd1,
        PH_FRAME = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]  first_header;
        logic [BYTE_W-1:0]  second_header;
        logic [BYTE_W-1:0]  end_marker;
        logic [COUNT_W-1:0] max_frame_len;
    } t_cfg;

    typedef struct packed {
        logic [POS_X_W-1:0] pos_x;
        logic [BYTE_W-1:0]  pos_y;
        logic [BYTE_W-1:0]  box_w;
        logic [BYTE_W-1:0]  box_h;
        logic               end_ok;
    } t_result;

endpackage

### rtl/tbh_cfg.sv
`timescale 1ns / 1ps

module tbh_cfg
    import tbh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_header  <= RST_FIRST_HEADER;
            r_cfg.second_header <= RST_SECOND_HEADER;
            r_cfg.end_marker    <= RST_END_MARKER;
            r_cfg.max_frame_len <= RST_MAX_FRAME_LEN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FIRST_HEADER:  r_cfg.first_header  <= i_cfg_data;
                CFG_SECOND_HEADER: r_cfg.second_header <= i_cfg_data;
                CFG_END_MARKER:    r_cfg.end_marker    <= i_cfg_data;
                CFG_MAX_FRAME_LEN: r_cfg.max_frame_len <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/tbh_core.sv
`timescale 1ns / 1ps

module tbh_core
    import tbh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output logic              o_emit,
    output t_result           o_result
);

    t_phase              r_phase, n_phase;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0]   r_hist [HIST_N];
    logic [BYTE_W-1:0]   n_hist [HIST_N];
    logic [COUNT_W-1:0]  w_count_inc;
    logic                w_is_end;
    logic                w_close;

    assign w_count_inc = (r_count < COUNT_MAX) ? r_count + 1'b1 : COUNT_MAX;
    assign w_is_end    = (i_byte == i_cfg.end_marker);
    assign w_close     = (w_count_inc >= i_cfg.max_frame_len) || w_is_end;

    // next state
    always_comb begin
        n_phase = PH_IDLE;
        unique case (r_phase)
            PH_IDLE:  n_phase = (i_byte == i_cfg.first_header) ? PH_HEAD1 : PH_IDLE;
            PH_HEAD1: n_phase = (i_byte == i_cfg.second_header) ? PH_FRAME : PH_IDLE;
            PH_FRAME: n_phase = w_close ? PH_DONE : PH_FRAME;
            PH_DONE:  n_phase = PH_IDLE;
            default:  n_phase = PH_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count = '0;
        for (int k = 0; k < HIST_N; k++) begin
            n_hist[k] = '0;
        end
        o_emit = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == i_cfg.first_header) begin
                    n_hist[0] = i_byte;
                    n_count   = COUNT_W'(1);
                end
            end
            PH_HEAD1: begin
                if (i_byte == i_cfg.second_header) begin
                    n_hist[0] = i_byte;
                    for (int k = 1; k < HIST_N; k++) begin
                        n_hist[k] = r_hist[k-1];
                    end
                    n_count = w_count_inc;
                end
            end
            PH_FRAME: begin
                n_hist[0] = i_byte;
                for (int k = 1; k < HIST_N; k++) begin
                    n_hist[k] = r_hist[k-1];
                end
                n_count = w_count_inc;
                o_emit  = w_close;
            end
            PH_DONE: ;
            default: ;
        endcase
        o_result.pos_x  = POS_X_W'(r_hist[3]) + POS_X_W'(r_hist[1]);
        o_result.pos_y  = r_hist[2];
        o_result.box_w  = r_hist[1];
        o_result.box_h  = r_hist[0];
        o_result.end_ok = w_is_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // history is cleared on every return to idle
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int k = 0; k < HIST_N; k++) begin
                r_hist[k] <= n_hist[k];
            end
        end
    end

endmodule

### rtl/two_byte_header_frame_parser.sv
`timescale 1ns / 1ps

// channel   valid        stall        payload
// input     i_in_valid   o_in_stall   i_rx_byte
// output    o_out_valid  i_out_stall  o_pos_x, o_pos_y, o_box_w, o_box_h, o_end_ok
// config    i_cfg_we     -            i_cfg_index, i_cfg_data
//
// one byte per cycle while o_in_stall is low; a closing byte beat passes the input
// register, then the result register, before its result leaves
// reset is synchronous: parser idle, valid flags cleared, config registers at their defaults
// an output stall holds the result register while it is valid, and the input register stalls
// only while it is full and the result register cannot move

module two_byte_header_frame_parser
    import tbh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [POS_X_W-1:0]   o_pos_x,
    output logic [BYTE_W-1:0]    o_pos_y,
    output logic [BYTE_W-1:0]    o_box_w,
    output logic [BYTE_W-1:0]    o_box_h,
    output logic                 o_end_ok,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_cfg              w_cfg;
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    t_result           r_out;
    logic              w_adv;
    logic              w_fire;
    logic              w_emit;
    t_result           w_result;

    tbh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_adv      = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && w_adv;
    assign o_in_stall = r_in_vld && !w_adv;

    tbh_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_fire && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pos_x     = r_out.pos_x;
    assign o_pos_y     = r_out.pos_y;
    assign o_box_w     = r_out.box_w;
    assign o_box_h     = r_out.box_h;
    assign o_end_ok    = r_out.end_ok;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import tbh_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                typed;
        t_result           res;
    } t_row;

    localparam int N_PHASES  = 10;
    localparam int PHASE_LEN = 143;
    localparam int HOLD_LEN  = 400;
    localparam int QUIET_MAX = 3000;
    localparam int SETTLE    = 4;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [BYTE_W-1:0]     i_rx_byte   = '0;
    logic [BYTE_W-1:0]     i_cfg_data  = '0;
    t_cfg_idx              i_cfg_index = CFG_FIRST_HEADER;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [POS_X_W-1:0]    o_pos_x;
    logic [BYTE_W-1:0]     o_pos_y;
    logic [BYTE_W-1:0]     o_box_w;
    logic [BYTE_W-1:0]     o_box_h;
    logic                  o_end_ok;

    // typed-in expectation travelling with the input beat
    bit      typed_tag = 1'b0;
    t_result typed_res = '0;

    bit idle_en  = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet = 0;
    int err_cnt = 0;
    int n_bytes = 0;
    int n_frames = 0;
    int n_end = 0;

    // parser copy kept by the bench
    t_phase            prs_phase = PH_IDLE;
    logic [COUNT_W-1:0] prs_count = '0;
    logic [BYTE_W-1:0] prs_hist [HIST_N];
    t_cfg              prs_cfg;
    t_result           frame_q [$];

    t_row dir_rows [19] = '{
        '{8'h5B, 1'b0, '0},
        // end marker right after the headers, leading bytes read as zero
        '{8'h2C, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{8'h5B, 1'b1, '{9'h02C, 8'h00, 8'h2C, 8'h12, 1'b1}},
        '{8'h2C, 1'b0, '0},
        // wrong second header
        '{8'h2C, 1'b0, '0},
        '{8'h2C, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        // full length frame of all ones
        '{8'h2C, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{9'h1FE, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{8'h00, 1'b0, '0}
    };

    t_cfg fixed_cfg [7] = '{
        '{8'h00, 8'hFF, 8'h00, 4'd15},
        '{8'hFF, 8'h00, 8'hFF, 4'd3},
        '{8'hA5, 8'h5A, 8'h3C, 4'd0},
        '{8'h2C, 8'h12, 8'h5B, 4'd10},
        '{8'h11, 8'h11, 8'h22, 4'd1},
        '{8'hC3, 8'h3C, 8'h7E, 4'd15},
        '{8'h5A, 8'hA5, 8'h5A, 4'd2}
    };

    two_byte_header_frame_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_box_w     (o_box_w),
        .o_box_h     (o_box_h),
        .o_end_ok    (o_end_ok),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void hunt_reset();
        prs_phase = PH_IDLE;
        prs_count = '0;
        foreach (prs_hist[k]) prs_hist[k] = '0;
    endfunction

    function automatic void shift_in(input logic [BYTE_W-1:0] b);
        for (int k = HIST_N - 1; k > 0; k--) prs_hist[k] = prs_hist[k-1];
        prs_hist[0] = b;
        if (prs_count != COUNT_MAX) prs_count++;
    endfunction

    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output t_result r);
        logic hit_end;
        hit_end = (b == prs_cfg.end_marker);
        r = '0;
        parse_byte = 1'b0;
        case (prs_phase)
            PH_IDLE: begin
                hunt_reset();
                if (b == prs_cfg.first_header) begin
                    shift_in(b);
                    prs_phase = PH_HEAD1;
                end
            end
            PH_HEAD1: begin
                if (b == prs_cfg.second_header) begin
                    shift_in(b);
                    prs_phase = PH_FRAME;
                end else begin
                    hunt_reset();
                end
            end
            PH_FRAME: begin
                r.pos_x  = POS_X_W'(prs_hist[3]) + POS_X_W'(prs_hist[1]);
                r.pos_y  = prs_hist[2];
                r.box_w  = prs_hist[1];
                r.box_h  = prs_hist[0];
                r.end_ok = hit_end;
                shift_in(b);
                if (prs_count >= prs_cfg.max_frame_len || hit_end) begin
                    prs_phase = PH_DONE;
                    parse_byte = 1'b1;
                end
            end
            default: hunt_reset();
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [POS_X_W-1:0] want,
                                        input logic [POS_X_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin : byte_mon
        t_result r;
        bit closes;
        if (!i_rst_n) begin
            prs_cfg = '{RST_FIRST_HEADER, RST_SECOND_HEADER, RST_END_MARKER,
                        RST_MAX_FRAME_LEN};
            hunt_reset();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRST_HEADER:  prs_cfg.first_header  = i_cfg_data;
                    CFG_SECOND_HEADER: prs_cfg.second_header = i_cfg_data;
                    CFG_END_MARKER:    prs_cfg.end_marker    = i_cfg_data;
                    CFG_MAX_FRAME_LEN: prs_cfg.max_frame_len = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                closes = parse_byte(i_rx_byte, r);
                n_bytes++;
                if (typed_tag) begin
                    frame_q.push_back(typed_res);
                end else if (closes) begin
                    frame_q.push_back(r);
                end
            end
        end
    end

    always @(posedge i_clk) begin : frame_mon
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_frames++;
            if (o_end_ok) n_end++;
            if (frame_q.size() == 0) begin
                $error("result beat with no frame expected");
                err_cnt++;
            end else begin
                want = frame_q.pop_front();
                check_field("pos_x", want.pos_x, o_pos_x);
                check_field("pos_y", POS_X_W'(want.pos_y), POS_X_W'(o_pos_y));
                check_field("box_w", POS_X_W'(want.box_w), POS_X_W'(o_box_w));
                check_field("box_h", POS_X_W'(want.box_h), POS_X_W'(o_box_h));
                check_field("end_ok", POS_X_W'(want.end_ok), POS_X_W'(o_end_ok));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_en && ($urandom_range(99) < 37);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input t_result res = '0);
        while (idle_en && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        typed_tag  <= typed;
        typed_res  <= res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frame_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FIRST_HEADER;
        i_cfg_data  <= c.first_header;
        @(posedge i_clk);
        i_cfg_index <= CFG_SECOND_HEADER;
        i_cfg_data  <= c.second_header;
        @(posedge i_clk);
        i_cfg_index <= CFG_END_MARKER;
        i_cfg_data  <= c.end_marker;
        @(posedge i_clk);
        // upper bits are don't-care for the length register
        i_cfg_index <= CFG_MAX_FRAME_LEN;
        i_cfg_data  <= {4'($urandom_range(15)), c.max_frame_len};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        t_cfg cur;
        int sent;
        int body;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k]) send_byte(dir_rows[k].rx, dir_rows[k].typed, dir_rows[k].res);
        settle();
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 7) begin
                cur = fixed_cfg[p];
            end else begin
                cur = '{BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                        COUNT_W'($urandom)};
            end
            load_cfg(cur);
            idle_en = (p != 5);
            if (p == 3) hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_LEN) begin
                case ($urandom_range(9))
                    0: begin
                        send_byte(rand_byte());
                        sent++;
                    end
                    1: begin
                        send_byte(cur.first_header);
                        send_byte(rand_byte());
                        sent += 2;
                    end
                    default: begin
                        send_byte(cur.first_header);
                        send_byte(cur.second_header);
                        body = $urandom_range(14);
                        repeat (body) send_byte(rand_byte());
                        if ($urandom_range(1)) send_byte(cur.end_marker);
                        send_byte(rand_byte());
                        sent += body + 4;
                    end
                endcase
            end
            settle();
        end
        $display("%0d bytes parsed over %0d register settings", n_bytes, N_PHASES + 1);
        $display("%0d frames checked, %0d closed by the end marker", n_frames, n_end);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
